>>> design/rrs_pkg.sv
package rrs_pkg;

  // Relocation type numbers from the x86-64 ELF ABI.
  localparam logic [31:0] RT_NONE   = 32'd0;
  localparam logic [31:0] RT_ABS64  = 32'd1;
  localparam logic [31:0] RT_PC32   = 32'd2;
  localparam logic [31:0] RT_PLT32  = 32'd4;
  localparam logic [31:0] RT_ABS32  = 32'd10;
  localparam logic [31:0] RT_ABS32S = 32'd11;
  localparam logic [31:0] RT_ABS16  = 32'd12;
  localparam logic [31:0] RT_PC16   = 32'd13;
  localparam logic [31:0] RT_ABS8   = 32'd14;
  localparam logic [31:0] RT_PC8    = 32'd15;
  localparam logic [31:0] RT_PC64   = 32'd24;
  localparam logic [31:0] RT_SIZE32 = 32'd32;
  localparam logic [31:0] RT_SIZE64 = 32'd33;

  // Exact sums need two bits above the 64-bit operands.
  localparam int unsigned WideW = 66;

  typedef logic signed [WideW-1:0] wide_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOTGT  = 2'd1,
    ST_RANGE  = 2'd2,
    ST_UNSUPP = 2'd3
  } status_t;

  // Decoded check to apply in the last stage.
  typedef enum logic [3:0] {
    K_NONE,
    K_WRAP,
    K_PC32,
    K_U32,
    K_S32,
    K_U16,
    K_PC16,
    K_U8,
    K_PC8,
    K_PC64,
    K_UNSUPP,
    K_NOTGT
  } kind_t;

  typedef struct packed {
    logic [31:0] reloc_type;
    logic [63:0] symbol_value;
    logic signed [63:0] addend;
    logic [63:0] place;
    logic        no_target;
  } rrs_req_t;

  typedef struct packed {
    logic [63:0] store_value;
    logic [3:0]  store_bytes;
    status_t     status;
  } rrs_res_t;

  typedef struct packed {
    kind_t       kind;
    wide_t       absv;
    logic [63:0] place;
  } rrs_s1_t;

  typedef struct packed {
    kind_t kind;
    wide_t absv;
    wide_t relv;
  } rrs_s2_t;

endpackage

>>> design/rrs_decode.sv
module rrs_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  rrs_pkg::rrs_req_t in_req,
  output logic              valid,
  output rrs_pkg::rrs_s1_t  data
);
  import rrs_pkg::*;

  rrs_s1_t data_next;

  always_comb begin
    data_next.place = in_req.place;
    // Exact S + A: zero-extend S, sign-extend A.
    data_next.absv  = wide_t'({2'b00, in_req.symbol_value})
                    + wide_t'({{2{in_req.addend[63]}}, in_req.addend});
    if (in_req.no_target) begin
      data_next.kind = K_NOTGT;
    end else begin
      unique case (in_req.reloc_type)
        RT_NONE:                  data_next.kind = K_NONE;
        RT_ABS64, RT_SIZE64:      data_next.kind = K_WRAP;
        RT_PC32, RT_PLT32:        data_next.kind = K_PC32;
        RT_ABS32, RT_SIZE32:      data_next.kind = K_U32;
        RT_ABS32S:                data_next.kind = K_S32;
        RT_ABS16:                 data_next.kind = K_U16;
        RT_PC16:                  data_next.kind = K_PC16;
        RT_ABS8:                  data_next.kind = K_U8;
        RT_PC8:                   data_next.kind = K_PC8;
        RT_PC64:                  data_next.kind = K_PC64;
        default:                  data_next.kind = K_UNSUPP;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      data <= data_next;
    end
  end

endmodule

>>> design/rrs_diff.sv
module rrs_diff (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             in_valid,
  input  rrs_pkg::rrs_s1_t in_data,
  output logic             valid,
  output rrs_pkg::rrs_s2_t data
);
  import rrs_pkg::*;

  rrs_s2_t data_next;

  always_comb begin
    data_next.kind = in_data.kind;
    data_next.absv = in_data.absv;
    data_next.relv = in_data.absv - wide_t'({2'b00, in_data.place});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      data <= data_next;
    end
  end

endmodule

>>> design/rrs_check.sv
module rrs_check (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  rrs_pkg::rrs_s2_t  in_data,
  output logic              valid,
  output rrs_pkg::rrs_res_t res
);
  import rrs_pkg::*;

  rrs_res_t res_next;

  // The value fits when every bit from bits-1 upward matches the sign.
  function automatic logic fits_s(wide_t w, int unsigned bits);
    wide_t t;
    t = w >>> (bits - 1);
    return (t == '0) || (t == '1);
  endfunction

  function automatic logic fits_u(wide_t w, int unsigned bits);
    return (w >> bits) == '0;
  endfunction

  function automatic logic [63:0] low_bits(wide_t w, int unsigned bits);
    return w[63:0] & ((64'd1 << bits) - 64'd1);
  endfunction

  function automatic rrs_res_t pick(logic ok, logic [63:0] v, logic [3:0] bytes);
    rrs_res_t r;
    if (ok) begin
      r.store_value = v;
      r.store_bytes = bytes;
      r.status      = ST_OK;
    end else begin
      r.store_value = '0;
      r.store_bytes = '0;
      r.status      = ST_RANGE;
    end
    return r;
  endfunction

  always_comb begin
    wide_t a;
    wide_t r;
    a = in_data.absv;
    r = in_data.relv;
    res_next = '{store_value: '0, store_bytes: '0, status: ST_OK};
    unique case (in_data.kind)
      K_NONE:   res_next = '{store_value: '0, store_bytes: '0, status: ST_OK};
      K_WRAP:   res_next = '{store_value: a[63:0], store_bytes: 4'd8, status: ST_OK};
      K_PC32:   res_next = pick(fits_s(r, 32), low_bits(r, 32), 4'd4);
      K_U32:    res_next = pick(fits_u(a, 32), low_bits(a, 32), 4'd4);
      K_S32:    res_next = pick(fits_s(a, 32), low_bits(a, 32), 4'd4);
      K_U16:    res_next = pick(fits_u(a, 16), low_bits(a, 16), 4'd2);
      K_PC16:   res_next = pick(fits_s(r, 16), low_bits(r, 16), 4'd2);
      K_U8:     res_next = pick(fits_u(a, 8), low_bits(a, 8), 4'd1);
      K_PC8:    res_next = pick(fits_s(r, 8), low_bits(r, 8), 4'd1);
      K_PC64:   res_next = pick(fits_s(r, 64), r[63:0], 4'd8);
      K_NOTGT:  res_next = '{store_value: '0, store_bytes: '0, status: ST_NOTGT};
      default:  res_next = '{store_value: '0, store_bytes: '0, status: ST_UNSUPP};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      res <= res_next;
    end
  end

endmodule

>>> design/x86_64_relocation_resolver_top.sv
// A request accepted at a clock edge is registered by the decode, diff and check stages
// in that order; the check stage drives its result on res.
// Throughput: one request per cycle, sustained, as long as res_ready stays high.
// A stalled result holds its stage; earlier stages keep filling until the pipe is full.
// Reset (rst, synchronous, active high) clears the valid bit of each of the three stages;
// the payload registers are not reset.
module x86_64_relocation_resolver_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  rrs_pkg::rrs_req_t req,
  output logic              res_valid,
  input  logic              res_ready,
  output rrs_pkg::rrs_res_t res
);
  import rrs_pkg::*;

  // Pipeline stages:
  //   1. decode the relocation type and form the exact sum S + A,
  //   2. form the exact PC-relative difference S + A - P,
  //   3. check the selected value against the type's range and build the result.
  // Each stage carries a valid bit beside its data. A stage advances when it is empty
  // or when the stage after it advances, so a stall reaches back only through stages that
  // are full, without dropping or duplicating a request.

  logic    v1;
  logic    v2;
  logic    adv1;
  logic    adv2;
  logic    adv3;
  rrs_s1_t d1;
  rrs_s2_t d2;

  assign adv3      = !res_valid || res_ready;
  assign adv2      = !v2 || adv3;
  assign adv1      = !v1 || adv2;
  assign req_ready = adv1;

  rrs_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv1),
    .in_valid (req_valid),
    .in_req   (req),
    .valid    (v1),
    .data     (d1)
  );

  rrs_diff u_diff (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv2),
    .in_valid (v1),
    .in_data  (d1),
    .valid    (v2),
    .data     (d2)
  );

  rrs_check u_check (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv3),
    .in_valid (v2),
    .in_data  (d2),
    .valid    (res_valid),
    .res      (res)
  );

  // A request held in the first stage while the second cannot take it stays there.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    v1 && !adv2 |=> v1 && $stable(d1))
    else $error("stage 1 request lost during stall");

  // Any non-ok status comes with nothing to store.
  a_err_empty: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status != ST_OK |-> res.store_bytes == 4'd0 && res.store_value == 64'd0)
    else $error("failed relocation carries store data");

  // Store width is one of the legal byte counts.
  a_bytes_legal: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.store_bytes == 4'd0 || res.store_bytes == 4'd1 ||
                  res.store_bytes == 4'd2 || res.store_bytes == 4'd4 ||
                  res.store_bytes == 4'd8)
    else $error("illegal store width");

  // The stored value never reaches above its byte width.
  a_value_width: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.store_bytes == 4'd1 || res.store_bytes == 4'd2 ||
                  res.store_bytes == 4'd4) |-> res.store_value[63:32] == 32'd0 &&
    (res.store_bytes == 4'd4 || res.store_value[31:16] == 16'd0) &&
    (res.store_bytes != 4'd1 || res.store_value[15:8] == 8'd0))
    else $error("store value wider than store width");

endmodule

>>> sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rrs_pkg::*;

  // The run ends here, as a failure, once the cycle count passes this limit.
  localparam int unsigned CycleLimit = 200000;
  // Random requests per handshake phase; with the directed set this comes to about 750.
  localparam int unsigned PhaseCount = 180;
  // Cycles to let pass after the last result, from the three-stage pipe.
  localparam int unsigned DrainCycles = 10;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_ready;
  rrs_req_t req = '0;
  logic     res_valid;
  logic     res_ready = 1'b0;
  rrs_res_t res;

  // Requests waiting to be driven, and results the resolver still owes, oldest first.
  rrs_req_t pending_relocs[$];
  rrs_res_t owed_results[$];

  // Percent of cycles in which the sender holds back and the receiver stalls.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned cycle_count = 0;
  int unsigned sent_count = 0;
  int unsigned checked_count = 0;
  int unsigned error_count = 0;
  int unsigned directed_count = 0;
  int unsigned status_seen[4] = '{0, 0, 0, 0};
  rrs_res_t    want_res;

  x86_64_relocation_resolver_top DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Resolves one relocation the way the loader would. The symbol value plus addend, and
  // that sum minus the place, are formed exactly in 68 signed bits, so neither a carry
  // out of bit 63 nor a borrow below zero is lost before the range check.
  function automatic rrs_res_t resolve_reloc(rrs_req_t r);
    logic signed [67:0] sum_abs;
    logic signed [67:0] sum_rel;
    logic signed [67:0] chk;
    logic signed [67:0] span;
    logic [63:0]        keep_mask;
    int unsigned        nbits;
    bit                 as_signed;
    bit                 checked;
    rrs_res_t           o;
    o = '0;
    o.status = ST_OK;
    nbits = 64;
    as_signed = 1'b0;
    checked = 1'b0;
    chk = '0;
    if (r.no_target) begin
      o.status = ST_NOTGT;
      return o;
    end
    sum_abs = $signed({4'b0000, r.symbol_value}) + $signed({{4{r.addend[63]}}, r.addend});
    sum_rel = sum_abs - $signed({4'b0000, r.place});
    case (r.reloc_type)
      RT_NONE: begin
      end
      RT_ABS64, RT_SIZE64: begin
        o.store_value = sum_abs[63:0];
        o.store_bytes = 4'd8;
      end
      RT_PC32, RT_PLT32: begin
        chk = sum_rel; nbits = 32; as_signed = 1'b1; checked = 1'b1;
      end
      RT_ABS32, RT_SIZE32: begin
        chk = sum_abs; nbits = 32; checked = 1'b1;
      end
      RT_ABS32S: begin
        chk = sum_abs; nbits = 32; as_signed = 1'b1; checked = 1'b1;
      end
      RT_ABS16: begin
        chk = sum_abs; nbits = 16; checked = 1'b1;
      end
      RT_PC16: begin
        chk = sum_rel; nbits = 16; as_signed = 1'b1; checked = 1'b1;
      end
      RT_ABS8: begin
        chk = sum_abs; nbits = 8; checked = 1'b1;
      end
      RT_PC8: begin
        chk = sum_rel; nbits = 8; as_signed = 1'b1; checked = 1'b1;
      end
      RT_PC64: begin
        chk = sum_rel; nbits = 64; as_signed = 1'b1; checked = 1'b1;
      end
      default: begin
        o.status = ST_UNSUPP;
      end
    endcase
    if (checked) begin
      span = 68'sd1 <<< nbits;
      keep_mask = (nbits == 64) ? '1 : (64'd1 << nbits) - 64'd1;
      if (as_signed ? (chk >= -(span >>> 1) && chk < (span >>> 1))
                    : (chk >= 68'sd0 && chk < span)) begin
        o.store_value = chk[63:0] & keep_mask;
        o.store_bytes = 4'(nbits / 8);
      end else begin
        o.status = ST_RANGE;
      end
    end
    return o;
  endfunction

  // One random relocation. Most use a supported type; the rest use a random 32-bit number or one from 0 to 63.
  // The values come in three flavors: fully random, symbol and place close together as
  // in a real image, and an addend solved so that the result lands next to a range edge.
  function automatic rrs_req_t random_reloc();
    rrs_req_t    r;
    logic [63:0] target;
    int unsigned k;
    bit          pc_rel;
    r.no_target = ($urandom_range(99) < 5);
    if ($urandom_range(99) < 8) begin
      r.reloc_type = $urandom_range(1) ? 32'($urandom) : 32'($urandom_range(63));
    end else begin
      case ($urandom_range(12))
        0:       r.reloc_type = RT_NONE;
        1:       r.reloc_type = RT_ABS64;
        2:       r.reloc_type = RT_PC32;
        3:       r.reloc_type = RT_PLT32;
        4:       r.reloc_type = RT_ABS32;
        5:       r.reloc_type = RT_ABS32S;
        6:       r.reloc_type = RT_ABS16;
        7:       r.reloc_type = RT_PC16;
        8:       r.reloc_type = RT_ABS8;
        9:       r.reloc_type = RT_PC8;
        10:      r.reloc_type = RT_PC64;
        11:      r.reloc_type = RT_SIZE32;
        default: r.reloc_type = RT_SIZE64;
      endcase
    end
    pc_rel = (r.reloc_type == RT_PC32) || (r.reloc_type == RT_PLT32) ||
             (r.reloc_type == RT_PC16) || (r.reloc_type == RT_PC8) ||
             (r.reloc_type == RT_PC64);
    case ($urandom_range(2))
      0: begin
        r.symbol_value = {$urandom, $urandom};
        r.addend       = {$urandom, $urandom};
        r.place        = {$urandom, $urandom};
      end
      1: begin
        target         = {$urandom, $urandom};
        r.symbol_value = target + 64'($urandom_range(255));
        r.place        = target + 64'($urandom_range(255));
        r.addend       = 64'($urandom_range(511)) - 64'd256;
      end
      default: begin
        case ($urandom_range(6))
          0:       k = 7;
          1:       k = 8;
          2:       k = 15;
          3:       k = 16;
          4:       k = 31;
          5:       k = 32;
          default: k = 63;
        endcase
        target = (64'd1 << k) + 64'($urandom_range(4)) - 64'd2;
        if ($urandom_range(1)) target = -target;
        r.symbol_value = {$urandom, $urandom} >> $urandom_range(63);
        r.place        = {$urandom, $urandom} >> $urandom_range(63);
        r.addend       = target - r.symbol_value + (pc_rel ? r.place : 64'd0);
      end
    endcase
    return r;
  endfunction

  task automatic queue_reloc(logic [31:0] t, logic [63:0] s, logic [63:0] a,
                             logic [63:0] p, logic nt);
    rrs_req_t r;
    r.reloc_type   = t;
    r.symbol_value = s;
    r.addend       = a;
    r.place        = p;
    r.no_target    = nt;
    pending_relocs.push_back(r);
    directed_count++;
  endtask

  // Holds the sender back until the queue is drained and every owed result has come back.
  task automatic wait_idle();
    while (pending_relocs.size() != 0 || req_valid || owed_results.size() != 0)
      @(posedge clk);
  endtask

  // Request driver. When the current request is taken, its expected result is owed.
  // A new request is presented only once the slot is free, so valid and the payload stay
  // put while the resolver is not ready.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        owed_results.push_back(resolve_reloc(req));
        sent_count++;
      end
      if (!req_valid || req_ready) begin
        if (pending_relocs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req       <= pending_relocs.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Each taken result is compared with the oldest owed one, field by field.
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        if (owed_results.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("unexpected result: value %h bytes %0d status %0d",
                     res.store_value, res.store_bytes, res.status);
        end else begin
          want_res = owed_results.pop_front();
          checked_count++;
          status_seen[want_res.status]++;
          if (res.store_value !== want_res.store_value ||
              res.store_bytes !== want_res.store_bytes ||
              res.status !== want_res.status) begin
            error_count++;
            if (error_count <= 10) begin
              $display("mismatch on result %0d: expected value %h bytes %0d status %0d",
                       checked_count, want_res.store_value, want_res.store_bytes,
                       want_res.status);
              $display("  got value %h bytes %0d status %0d",
                       res.store_value, res.store_bytes, res.status);
            end
          end
        end
      end
      res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles with %0d results still owed",
               cycle_count, owed_results.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed set, driven back to back with no idling. It walks each relocation type
    // across its range edges, the wrap of the 64-bit types, a symbol plus addend that
    // carries past bit 63, a missing target, and type numbers the resolver does not know.
    queue_reloc(RT_NONE,   64'h1234,                 64'd0,          64'd0,         1'b0);
    queue_reloc(RT_NONE,   64'h1234,                 64'd0,          64'd0,         1'b1);
    queue_reloc(RT_ABS64,  '1,                       64'd1,          64'd0,         1'b0);
    queue_reloc(RT_SIZE64, 64'd0,                    '1,             64'd0,         1'b0);
    queue_reloc(RT_PC32,   64'hFFFF_FFFF_0000_0000,  64'h7FFF_FFFF,
                64'hFFFF_FFFF_0000_0000, 1'b0);
    queue_reloc(RT_PC32,   64'hFFFF_FFFF_0000_0000,  64'h8000_0000,
                64'hFFFF_FFFF_0000_0000, 1'b0);
    queue_reloc(RT_PLT32,  64'd0,                    64'd0,          64'h8000_0000, 1'b0);
    queue_reloc(RT_ABS32,  64'hFFFF_0000,            64'hFFFF,       64'd0,         1'b0);
    queue_reloc(RT_ABS32,  64'd0,                    '1,             64'd0,         1'b0);
    queue_reloc(RT_SIZE32, '1,                       64'd1,          64'd0,         1'b0);
    queue_reloc(RT_ABS32S, 64'd0,                    -64'h8000_0000, 64'd0,         1'b0);
    queue_reloc(RT_ABS32S, 64'h8000_0000,            64'd0,          64'd0,         1'b0);
    queue_reloc(RT_ABS16,  64'hFF00,                 64'hFF,         64'd0,         1'b0);
    queue_reloc(RT_ABS16,  64'h1_0000,               64'd0,          64'd0,         1'b0);
    queue_reloc(RT_PC16,   64'h1000,                 64'd0,          64'h9000,      1'b0);
    queue_reloc(RT_PC16,   64'h9000,                 64'd0,          64'h1000,      1'b0);
    queue_reloc(RT_ABS8,   64'd0,                    64'hFF,         64'd0,         1'b0);
    queue_reloc(RT_ABS8,   64'h80,                   64'h80,         64'd0,         1'b0);
    queue_reloc(RT_PC8,    '1,                       64'd1,
                64'hFFFF_FFFF_FFFF_FF81, 1'b0);
    queue_reloc(RT_PC8,    64'd0,                    -64'h81,        64'd0,         1'b0);
    queue_reloc(RT_PC64,   '1,                       64'd0,          64'd0,         1'b0);
    queue_reloc(RT_PC64,   64'd0,                    64'd0,          64'd1,         1'b0);
    queue_reloc(RT_PC64,   64'd0,                    64'h8000_0000_0000_0000,
                64'd1, 1'b0);
    queue_reloc(32'd3,     64'h55,                   64'd0,          64'd0,         1'b0);
    queue_reloc('1,        '1,                       '1,             '1,            1'b0);
    // The sender then pauses until every directed result has come back.
    wait_idle();

    // Random phases: no idling, a slow sender, a slow receiver, then both at once.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 63 : (ph == 3) ? 22 : 0;
      recv_stall_pct = (ph == 2) ? 63 : (ph == 3) ? 22 : 0;
      for (int n = 0; n < PhaseCount; n++)
        pending_relocs.push_back(random_reloc());
      wait_idle();
    end

    repeat (DrainCycles) @(posedge clk);

    $display("covered %0d relocations (%0d directed) under four handshake phases",
             sent_count, directed_count);
    $display("results checked %0d: ok %0d, no target %0d, out of range %0d, unknown type %0d",
             checked_count, status_seen[ST_OK], status_seen[ST_NOTGT],
             status_seen[ST_RANGE], status_seen[ST_UNSUPP]);
    if (error_count == 0 && owed_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d errors, %0d results never arrived", error_count, owed_results.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/rrs_pkg.sv
design/rrs_decode.sv
design/rrs_diff.sv
design/rrs_check.sv
design/x86_64_relocation_resolver_top.sv
sim/testbench.sv
